// ===== hw/rtl/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH      = 16;
    localparam int PRIO_WIDTH = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_ENQ,
        OP_DEQ
    } cell_op_t;

    typedef struct packed {
        logic signed [PRIO_WIDTH-1:0] prio;
        logic signed [DATA_WIDTH-1:0] data;
    } entry_t;

    // broadcast to every cell in the chain
    typedef struct packed {
        cell_op_t op;
        entry_t   ent;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  logic       left_gt,
    input  entry_t     left_ent,
    input  entry_t     right_ent,
    output logic       gt,
    output entry_t     ent
);

    entry_t ent_reg;
    entry_t ent_next;

    // strict compare keeps equal priorities in arrival order
    assign gt  = !occupied || (ctrl.ent.prio > ent_reg.prio);
    assign ent = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        case (ctrl.op)
            OP_ENQ:
            begin
                if (gt)
                begin
                    ent_next = left_gt ? left_ent : ctrl.ent;
                end
            end
            OP_DEQ:
            begin
                ent_next = right_ent;
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps

// Sorted priority queue of DEPTH (priority, data) entries, highest signed
// priority at the head, equal priorities served oldest first.
// Input channel: in_valid/in_ready carry func, new_prio, new_data.
//   func 0 inserts the entry, func 1 removes the head entry.
// Result channel: res_valid/res_ready carry status, out_valid, out_prio,
//   out_data and count (entries held after the step).
// For each accepted beat, every cell of the chain compares the
// new priority with its own entry at once and shifts or loads in parallel.
// The result is registered, so it appears the cycle after the input beat.
// One beat per cycle is sustained while the receiver takes results; the
// single result register is the only buffering, so in_ready follows
// res_ready when a result is waiting.
// A full insert returns overflow, an empty remove underflow; the queue is
// then unchanged. Reset empties the queue and drops any pending result.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic signed [PRIO_WIDTH-1:0] new_prio,
    input  logic signed [DATA_WIDTH-1:0] new_data,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic [1:0]                   status,
    output logic                         out_valid,
    output logic signed [PRIO_WIDTH-1:0] out_prio,
    output logic signed [DATA_WIDTH-1:0] out_data,
    output logic [CNT_W-1:0]             count
);

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         res_valid_reg;
    logic                         res_valid_next;
    logic [1:0]                   status_reg;
    logic [1:0]                   status_next;
    logic                         ovalid_reg;
    logic                         ovalid_next;
    logic signed [PRIO_WIDTH-1:0] oprio_reg;
    logic signed [PRIO_WIDTH-1:0] oprio_next;
    logic signed [DATA_WIDTH-1:0] odata_reg;
    logic signed [DATA_WIDTH-1:0] odata_next;

    logic       accept;
    logic       full;
    logic       empty;
    cell_ctrl_t ctrl;
    entry_t     cell_ent [DEPTH];
    logic       cell_gt  [DEPTH];

    assign in_ready = !res_valid_reg || res_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        ctrl.ent.prio = new_prio;
        ctrl.ent.data = new_data;
        ctrl.op       = OP_HOLD;
        if (accept)
        begin
            if (!func && !full)
            begin
                ctrl.op = OP_ENQ;
            end
            else if (func && !empty)
            begin
                ctrl.op = OP_DEQ;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
            logic   left_gt;
            entry_t left_ent;
            entry_t right_ent;

            if (g == 0)
            begin : g_head
                assign left_gt  = 1'b0;
                assign left_ent = ctrl.ent;
            end
            else
            begin : g_body
                assign left_gt  = cell_gt[g-1];
                assign left_ent = cell_ent[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign right_ent = ctrl.ent;
            end
            else
            begin : g_mid
                assign right_ent = cell_ent[g+1];
            end

            spq_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (IDX < count_reg),
                .left_gt   (left_gt),
                .left_ent  (left_ent),
                .right_ent (right_ent),
                .gt        (cell_gt[g]),
                .ent       (cell_ent[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        res_valid_next = res_valid_reg && !res_ready;
        status_next    = status_reg;
        ovalid_next    = ovalid_reg;
        oprio_next     = oprio_reg;
        odata_next     = odata_reg;
        if (accept)
        begin
            res_valid_next = 1'b1;
            status_next    = ST_OK;
            ovalid_next    = 1'b0;
            oprio_next     = '0;
            odata_next     = '0;
            if (!func)
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    ovalid_next = 1'b1;
                    oprio_next  = cell_ent[0].prio;
                    odata_next  = cell_ent[0].data;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        ovalid_reg <= ovalid_next;
        oprio_reg  <= oprio_next;
        odata_reg  <= odata_next;
    end

    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign out_valid = ovalid_reg;
    assign out_prio  = oprio_reg;
    assign out_data  = odata_reg;
    assign count     = count_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && status_reg == ST_OVERFLOW) |-> full)
        else $error("overflow reported while not full");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && status_reg == ST_UNDERFLOW) |-> empty)
        else $error("underflow reported while not empty");

    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func && !empty) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("dequeue did not lower the count");

    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && ovalid_reg) |-> (status_reg == ST_OK))
        else $error("returned entry with error status");
`endif

endmodule
